// ===== sv/hfsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hfsc_pkg: shared types and constants of the header/footer signature carver
// Request payloads, configuration register indexes and the configuration
// bundle that goes from the register file to the scan logic.
// ----------------------------------------------------------------------------
package hfsc_pkg;

  localparam int unsigned MaxSigBytesDef = 8;
  localparam int unsigned OffsetBitsDef  = 32;

  localparam int unsigned PatW     = 64;
  localparam int unsigned LenRawW  = 4;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned FieldW   = 32;

  localparam logic [LenRawW-1:0] LenResetVal = 4'd8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER_PATTERN = 2'd0,
    CFG_HEADER_LENGTH  = 2'd1,
    CFG_FOOTER_PATTERN = 2'd2,
    CFG_FOOTER_LENGTH  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [PatW-1:0]    hdr_pattern;
    logic [LenRawW-1:0] hdr_len;
    logic [PatW-1:0]    ftr_pattern;
    logic [LenRawW-1:0] ftr_len;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [FieldW-1:0] region_start;
    logic [FieldW-1:0] region_end;
    logic [FieldW-1:0] carved_total;
  } out_item_t;

endpackage
`default_nettype wire

// ===== sv/hfsc_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hfsc_stream_if: valid/ready request channel
// Carries one payload per request; a request moves when valid and ready
// are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface hfsc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== sv/header_footer_signature_carver_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// header_footer_signature_carver_unit: header/footer file carving scanner
// Scans a byte stream for a header signature, then the first footer after
// it, and reports the carved region with a saturating region count.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one byte per request (data_byte, end_of_buffer). end_of_buffer
//           marks the last byte of a buffer; offsets restart at zero after it.
//   out_o : one request per carved region (region_start, region_end exclusive,
//           carved_total).
//   cfg   : write port, cfg_we_i/cfg_idx_i/cfg_data_i; write only while idle.
// Throughput is one byte per cycle while out_o takes results. A byte is
// scanned against the window while it sits in the input register, and the
// result register loads when that byte advances out of it: a result passes
// through the input register and then the result register.
// Reset clears the search state and the count; lengths return to 8 and
// patterns to zero. When out_o stalls, the result holds, one more byte
// sits in the input register, and in_i.ready drops until out_o drains.
// ----------------------------------------------------------------------------
module header_footer_signature_carver_unit #(
  parameter int unsigned MaxSigBytes = hfsc_pkg::MaxSigBytesDef,
  parameter int unsigned OffsetBits  = hfsc_pkg::OffsetBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [hfsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [hfsc_pkg::CfgDataW-1:0] cfg_data_i,
  hfsc_stream_if.sink                        in_i,
  hfsc_stream_if.source                      out_o
);
  import hfsc_pkg::*;

  localparam int unsigned WinW = 8 * MaxSigBytes;
  localparam int unsigned LenW = $clog2(MaxSigBytes + 1);

  cfg_t cfg;

  logic                  s1_valid_q, s1_valid_d;
  in_item_t              s1_item_q;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_item_q, out_item_d;

  logic [WinW-1:0]       window_q, window_d, win_new;
  logic [OffsetBits-1:0] offset_q, offset_d, offset_inc;
  logic                  seek_ftr_q, seek_ftr_d;
  logic [LenW-1:0]       since_q, since_d, since_inc;
  logic [OffsetBits-1:0] hdr_start_q, hdr_start_d;
  logic [FieldW-1:0]     count_q, count_d;

  logic                  in_acc, adv;
  logic                  hdr_match, ftr_match, hdr_hit, ftr_hit;
  logic [LenW-1:0]       hdr_len, ftr_len;

  hfsc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign adv        = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || adv;
  assign in_acc     = in_i.valid && in_i.ready;

  // newest byte enters at the top of the window
  assign win_new    = (window_q >> 8) | (WinW'(s1_item_q.data_byte) << (WinW - 8));
  assign since_inc  = (since_q < LenW'(MaxSigBytes)) ? since_q + LenW'(1) : since_q;
  assign offset_inc = offset_q + OffsetBits'(1);

  hfsc_sig_match #(.MaxSigBytes(MaxSigBytes)) u_hdr_match (
    .window_i  (win_new),
    .pattern_i (cfg.hdr_pattern),
    .len_raw_i (cfg.hdr_len),
    .since_i   (since_inc),
    .len_o     (hdr_len),
    .match_o   (hdr_match)
  );

  hfsc_sig_match #(.MaxSigBytes(MaxSigBytes)) u_ftr_match (
    .window_i  (win_new),
    .pattern_i (cfg.ftr_pattern),
    .len_raw_i (cfg.ftr_len),
    .since_i   (since_inc),
    .len_o     (ftr_len),
    .match_o   (ftr_match)
  );

  assign hdr_hit = !seek_ftr_q && hdr_match;
  assign ftr_hit = seek_ftr_q && ftr_match && (ftr_len != '0);

  always_comb begin
    window_d    = window_q;
    offset_d    = offset_q;
    seek_ftr_d  = seek_ftr_q;
    since_d     = since_q;
    hdr_start_d = hdr_start_q;
    count_d     = count_q;
    if (adv) begin
      window_d = win_new;
      offset_d = offset_inc;
      since_d  = since_inc;
      if (hdr_hit) begin
        hdr_start_d = offset_q - OffsetBits'(hdr_len) + OffsetBits'(1);
        seek_ftr_d  = 1'b1;
        since_d     = '0;
      end
      if (ftr_hit) begin
        if (count_q != '1) begin
          count_d = count_q + FieldW'(1);
        end
        seek_ftr_d = 1'b0;
        since_d    = '0;
      end
      if (s1_item_q.end_of_buffer) begin
        window_d    = '0;
        offset_d    = '0;
        seek_ftr_d  = 1'b0;
        since_d     = '0;
        hdr_start_d = '0;
      end
    end
  end

  always_comb begin
    out_item_d.region_start = FieldW'(hdr_start_q);
    out_item_d.region_end   = FieldW'(offset_inc);
    out_item_d.carved_total = count_d;
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (adv) begin
      s1_valid_d = 1'b0;
    end
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (adv && ftr_hit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      window_q    <= '0;
      offset_q    <= '0;
      seek_ftr_q  <= 1'b0;
      since_q     <= '0;
      hdr_start_q <= '0;
      count_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      window_q    <= window_d;
      offset_q    <= offset_d;
      seek_ftr_q  <= seek_ftr_d;
      since_q     <= since_d;
      hdr_start_q <= hdr_start_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_i.payload;
    end
    if (adv && ftr_hit) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

  // a new result only follows a scan made while seeking a footer
  a_result_from_footer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(seek_ftr_q))
    else $error("result without pending header");

  a_since_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    since_q <= LenW'(MaxSigBytes))
    else $error("byte count since mark out of range");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count_q >= $past(count_q))
    else $error("region count decreased");

  a_eob_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && s1_item_q.end_of_buffer |=> offset_q == '0 && !seek_ftr_q && since_q == '0)
    else $error("search state not cleared at buffer end");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(out_item_q))
    else $error("pending result overwritten");

endmodule
`default_nettype wire

// ===== sv/hfsc_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hfsc_cfg_regs: configuration register file
// Write-only registers for the header and footer signatures and lengths.
// ----------------------------------------------------------------------------
module hfsc_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [hfsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [hfsc_pkg::CfgDataW-1:0] cfg_data_i,
  output hfsc_pkg::cfg_t                     cfg_o
);
  import hfsc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HEADER_PATTERN: cfg_d.hdr_pattern = cfg_data_i[PatW-1:0];
        CFG_HEADER_LENGTH:  cfg_d.hdr_len     = cfg_data_i[LenRawW-1:0];
        CFG_FOOTER_PATTERN: cfg_d.ftr_pattern = cfg_data_i[PatW-1:0];
        CFG_FOOTER_LENGTH:  cfg_d.ftr_len     = cfg_data_i[LenRawW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hdr_pattern <= '0;
      cfg_q.hdr_len     <= LenResetVal;
      cfg_q.ftr_pattern <= '0;
      cfg_q.ftr_len     <= LenResetVal;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== sv/hfsc_sig_match.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hfsc_sig_match: sliding window signature compare
// Clamps the signature length and compares the newest bytes of the window
// with the pattern, oldest byte against pattern byte 0.
// ----------------------------------------------------------------------------
module hfsc_sig_match #(
  parameter int unsigned MaxSigBytes = hfsc_pkg::MaxSigBytesDef,
  localparam int unsigned WinW = 8 * MaxSigBytes,
  localparam int unsigned LenW = $clog2(MaxSigBytes + 1)
) (
  input  wire logic [WinW-1:0]                window_i,
  input  wire logic [hfsc_pkg::PatW-1:0]      pattern_i,
  input  wire logic [hfsc_pkg::LenRawW-1:0]   len_raw_i,
  input  wire logic [LenW-1:0]                since_i,
  output logic      [LenW-1:0]                len_o,
  output logic                                match_o
);
  import hfsc_pkg::*;

  logic [LenW-1:0]        len;
  logic [LenW-1:0]        shamt;
  logic [WinW-1:0]        recent;
  logic [MaxSigBytes-1:0] byte_ok;

  always_comb begin
    priority if (len_raw_i == '0) begin
      len = LenW'(1);
    end else if (len_raw_i > LenRawW'(MaxSigBytes)) begin
      len = LenW'(MaxSigBytes);
    end else begin
      len = LenW'(len_raw_i);
    end
  end

  // newest len bytes moved down to byte 0
  assign shamt  = LenW'(MaxSigBytes) - len;
  assign recent = window_i >> {shamt, 3'b000};

  always_comb begin
    for (int j = 0; j < MaxSigBytes; j++) begin
      byte_ok[j] = (LenW'(j) >= len) || (recent[8*j +: 8] == pattern_i[8*j +: 8]);
    end
  end

  assign len_o   = len;
  assign match_o = (&byte_ok) && (since_i >= len);

endmodule
`default_nettype wire
